// ----- rtl/range_min_max_sum_engine_unit_defines.svh -----
// Assertion macros shared by the range engine RTL.
`ifndef RANGE_MIN_MAX_SUM_ENGINE_UNIT_DEFINES_SVH
`define RANGE_MIN_MAX_SUM_ENGINE_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define RMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rmmse_pkg.sv -----
package rmmse_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int INDEX_W    = 10;
  localparam int VALUE_W    = 32;
  localparam int LEN_W      = 11;
  localparam int OPCODE_W   = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam int FIRST_LSB  = 0;
  localparam int LAST_LSB   = FIRST_LSB + INDEX_W;
  localparam int WVAL_LSB   = LAST_LSB + INDEX_W;
  localparam int IN_TDATA_W = ((WVAL_LSB + VALUE_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 3'd0,
    OP_MAX   = 3'd1,
    OP_MIN   = 3'd2,
    OP_SUM   = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5
  } opcode_t;

endpackage

// ----- rtl/range_min_max_sum_engine_unit.sv -----
// Writes follow back to back; an index error passes through ST_RESULT to the output
// register, and the input is freed in the same cycle that the result is loaded there.
// Queries walk the range in ST_WALK, then pass ST_DRAIN and ST_RESULT; the result is
// loaded and the next item taken in the same cycle. Add and subtract walk and drain the
// range and give a result only on an index error; the range is walked one element a cycle,
// and m_tready stalls can hold results; synchronous reset keeps the store and sets used_length 1024.
`include "range_min_max_sum_engine_unit_defines.svh"

module range_min_max_sum_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [rmmse_pkg::LEN_W-1:0]       cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // first_index [9:0], last_index [19:10], write_value [51:20], zero fill above.
  input  logic [rmmse_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode [2:0].
  input  logic [rmmse_pkg::OPCODE_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // result_value [31:0].
  output logic [rmmse_pkg::VALUE_W-1:0]     m_tdata,
  // status [0].
  output logic                              m_tuser
);
  import rmmse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t              state;
  opcode_t             op;
  logic [LEN_W-1:0]    used_length;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   hi;
  logic [ADDR_W-1:0]   rd_idx;
  logic                rd_valid;
  logic [VALUE_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  acc;
  logic [VALUE_W-1:0]  acc_next;
  logic                acc_empty;
  logic [VALUE_W-1:0]  res_value;
  logic                res_status;

  logic [VALUE_W-1:0]  mem [MAX_LENGTH];

  opcode_t             in_op;
  logic [INDEX_W-1:0]  in_first;
  logic [INDEX_W-1:0]  in_last;
  logic [VALUE_W-1:0]  in_wval;
  logic [LEN_W-1:0]    len_eff;
  logic                first_err;
  logic                last_err;
  logic                accept;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  assign in_op    = opcode_t'(s_tuser);
  assign in_first = s_tdata[FIRST_LSB +: INDEX_W];
  assign in_last  = s_tdata[LAST_LSB +: INDEX_W];
  assign in_wval  = s_tdata[WVAL_LSB +: VALUE_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign len_eff   = (int'(used_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : used_length;
  assign first_err = ({1'b0, in_first} >= len_eff);
  assign last_err  = ({1'b0, in_last} >= len_eff);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data + VALUE_W'(1);
    if (accept && (in_op == OP_WRITE) && !first_err) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(in_first);
      wr_data = in_wval;
    end else if (rd_valid && (op == OP_ADD)) begin
      wr_en = 1'b1;
    end else if (rd_valid && (op == OP_SUB)) begin
      wr_en   = 1'b1;
      wr_data = rd_data - VALUE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx];
  end

  always_comb begin
    acc_next = acc;
    if (acc_empty) begin
      acc_next = rd_data;
    end else begin
      case (op)
        OP_MAX: begin
          if ($signed(rd_data) > $signed(acc)) acc_next = rd_data;
        end
        OP_MIN: begin
          if ($signed(rd_data) < $signed(acc)) acc_next = rd_data;
        end
        OP_SUM: begin
          acc_next = acc + rd_data;
        end
        default: begin
          acc_next = acc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      rd_valid    <= 1'b0;
      used_length <= LEN_RESET;
    end else begin
      if (cfg_wen) begin
        used_length <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == ST_WALK);
      if (rd_valid) begin
        acc       <= acc_next;
        acc_empty <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op         <= in_op;
            acc_empty  <= 1'b1;
            res_value  <= '0;
            res_status <= 1'b1;
            case (in_op)
              OP_WRITE: begin
                if (first_err) state <= ST_RESULT;
              end
              OP_MAX, OP_MIN, OP_SUM: begin
                if (first_err || last_err) begin
                  state <= ST_RESULT;
                end else begin
                  idx   <= ADDR_W'((in_first < in_last) ? in_first : in_last);
                  hi    <= ADDR_W'((in_first < in_last) ? in_last : in_first);
                  state <= ST_WALK;
                end
              end
              OP_ADD, OP_SUB: begin
                if (first_err || last_err) begin
                  state <= ST_RESULT;
                end else if (in_first <= in_last) begin
                  idx   <= ADDR_W'(in_first);
                  hi    <= ADDR_W'(in_last);
                  state <= ST_WALK;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WALK: begin
          rd_idx <= idx;
          if (idx == hi) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if ((op == OP_ADD) || (op == OP_SUB)) begin
            state <= ST_IDLE;
          end else begin
            res_value  <= acc_next;
            res_status <= 1'b0;
            state      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RMM_ASSERT(a_walk_in_range, (state == ST_WALK) |-> (idx <= hi), "walk index passed range end")
  `RMM_ASSERT(a_drain_has_data, (state == ST_DRAIN) |-> rd_valid, "drain without read data")
  `RMM_ASSERT(a_error_zero_value, (m_tvalid && m_tuser) |-> (m_tdata == '0), "error result not zero")
  `RMM_ASSERT(a_bad_write_reports, (accept && (in_op == OP_WRITE) && first_err) |=> ((state == ST_RESULT) && res_status), "bad write index not reported")
  `RMM_ASSERT_ALWAYS(a_reset_length, $past(rst) |-> (used_length == LEN_RESET), "used length not reset")

endmodule
